[sv/bts_pkg.sv]
package bts_pkg;

	localparam int IMG_W_BITS    = 11;
	localparam int IMG_H_BITS    = 12;
	localparam int CFG_DATA_BITS = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int COL_BITS      = 3;
	localparam int MIN_DIM       = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PASS_PARITY  = 2'd2;

	localparam logic PARITY_FIRST = 1'b0;

	localparam logic [3:0] B_MIN = 4'd2;
	localparam logic [3:0] B_MAX = 4'd6;

	// One window column: bit 0 top, bit 1 middle, bit 2 bottom.
	typedef logic [COL_BITS-1:0] col_t;

	// Ring holds the neighbors p2..p9 in bits 0..7, clockwise from north.
	function automatic logic thin_remove(input logic [7:0] ring, input logic parity);
		logic [2:0] trans;
		logic [3:0] cnt;
		logic       m1;
		logic       m2;
		trans = '0;
		cnt   = '0;
		for (int i = 0; i < 8; i++) begin
			if (!ring[i] && ring[(i + 1) % 8]) begin
				trans = trans + 3'd1;
			end
			cnt = cnt + 4'(ring[i]);
		end
		if (parity == PARITY_FIRST) begin
			m1 = ring[0] & ring[2] & ring[4];
			m2 = ring[2] & ring[4] & ring[6];
		end else begin
			m1 = ring[0] & ring[2] & ring[6];
			m2 = ring[0] & ring[4] & ring[6];
		end
		return (trans == 3'd1) && (cnt >= B_MIN) && (cnt <= B_MAX) && !m1 && !m2;
	endfunction

endpackage

[sv/bts_ram.sv]
module bts_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/bts_col_cell.sv]
module bts_col_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift_en,
	input  bts_pkg::col_t col_in,
	output bts_pkg::col_t col
);

	bts_pkg::col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col = col_q;

endmodule

[sv/binary_thinning_subpass.sv]
// Channel  | Handshake            | Word
// ---------+----------------------+----------------------------------------
// config   | cfg_we               | cfg_index, cfg_data
// input    | in_valid / in_ready  | pixel_in, is_pad
// output   | out_valid / out_ready| pixel_out, was_removed, frame_last
//
// One word is taken per clock unless the window stage stalls.
// The first image_width+1 words of a frame fill the two line delays and give
// no result; the line delays sit in one two-bit RAM read ahead of use.
// Reset clears the counters, the window cells and the output register.
// The window stage stalls only when it holds a result and the output
// register is full and not being taken.
module binary_thinning_subpass #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bts_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              pixel_in,
	input  logic                              is_pad,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              pixel_out,
	output logic                              was_removed,
	output logic                              frame_last
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 2);
	localparam int CW = (WW > bts_pkg::IMG_W_BITS) ? WW : bts_pkg::IMG_W_BITS;
	localparam int HW = bts_pkg::IMG_H_BITS;
	localparam logic [CW-1:0] MAX_W_C  = CW'(MAX_WIDTH);
	localparam logic [CW-1:0] MIN_W_C  = CW'(bts_pkg::MIN_DIM);
	localparam logic [HW-1:0] MIN_H_C  = HW'(bts_pkg::MIN_DIM);
	localparam logic [AW-1:0] COL_MASK = AW'(MAX_WIDTH - 1);

	logic [bts_pkg::IMG_W_BITS-1:0] image_width_q;
	logic [HW-1:0]                  image_height_q;
	logic                           pass_parity_q;

	logic [WW-1:0] fill_q;
	logic [AW-1:0] ocol_q;
	logic [HW-1:0] orow_q;

	logic [CW-1:0] w_raw;
	logic [CW-1:0] w_clamp;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [WW-1:0] ocol_inc;
	logic [HW:0]   orow_inc;
	logic [WW-1:0] col_full;
	logic [AW-1:0] col_now;
	logic          emit_now;
	logic          col_wrap;
	logic          row_wrap;
	logic          interior_now;
	logic          accept;

	logic          valid_s1;
	logic          x_s1;
	logic [AW-1:0] col_s1;
	logic          emit_s1;
	logic          interior_s1;
	logic          last_s1;
	logic          fwd_s1;
	logic [1:0]    byp_s1;
	logic          fire_s1;

	logic [1:0]    ram_rdata;
	logic [1:0]    line;
	logic [1:0]    wr_data;
	bts_pkg::col_t new_col;
	bts_pkg::col_t win [4];
	logic [7:0]    ring;
	logic          center;
	logic          removed;

	logic out_valid_q;
	logic pixel_out_q;
	logic was_removed_q;
	logic frame_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bts_pkg::IMG_W_BITS'(640);
			image_height_q <= HW'(480);
			pass_parity_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bts_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[bts_pkg::IMG_W_BITS-1:0];
				end
				bts_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[HW-1:0];
				end
				bts_pkg::REG_PASS_PARITY: begin
					pass_parity_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign w_raw = CW'(image_width_q);

	always_comb begin
		priority if (w_raw < MIN_W_C) begin
			w_clamp = MIN_W_C;
		end else if (w_raw > MAX_W_C) begin
			w_clamp = MAX_W_C;
		end else begin
			w_clamp = w_raw;
		end
	end

	assign w_eff    = w_clamp[WW-1:0];
	assign h_eff    = (image_height_q < MIN_H_C) ? MIN_H_C : image_height_q;
	assign ocol_inc = WW'(ocol_q) + WW'(1);
	assign orow_inc = {1'b0, orow_q} + {{HW{1'b0}}, 1'b1};
	assign emit_now = fill_q > w_eff;
	assign col_wrap = ocol_inc >= w_eff;
	assign row_wrap = orow_inc >= {1'b0, h_eff};
	assign interior_now = (orow_q != '0) && (orow_inc < {1'b0, h_eff}) &&
		(ocol_q != '0) && !col_wrap;

	always_comb begin
		if (!emit_now) begin
			col_full = (fill_q >= w_eff) ? '0 : fill_q;
		end else begin
			col_full = col_wrap ? '0 : ocol_inc;
		end
	end

	assign col_now  = col_full[AW-1:0] & COL_MASK;
	assign accept   = in_valid && in_ready;
	assign fire_s1  = valid_s1 && (!emit_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (!emit_now) begin
				fill_q <= fill_q + WW'(1);
			end else if (col_wrap) begin
				ocol_q <= '0;
				if (row_wrap) begin
					orow_q <= '0;
					fill_q <= '0;
				end else begin
					orow_q <= orow_inc[HW-1:0];
				end
			end else begin
				ocol_q <= ocol_inc[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			emit_s1     <= 1'b0;
			interior_s1 <= 1'b0;
			last_s1     <= 1'b0;
			fwd_s1      <= 1'b0;
		end else if (accept) begin
			valid_s1    <= 1'b1;
			emit_s1     <= emit_now;
			interior_s1 <= interior_now;
			last_s1     <= emit_now && col_wrap && row_wrap;
			fwd_s1      <= fire_s1 && (col_now == col_s1);
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= pixel_in && !is_pad;
			col_s1 <= col_now;
			byp_s1 <= wr_data;
		end
	end

	bts_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (fire_s1),
		.waddr(col_s1),
		.wdata(wr_data),
		.re   (accept),
		.raddr(col_now),
		.rdata(ram_rdata)
	);

	// Bit 0 of a line entry is the previous row, bit 1 the row before it.
	assign line    = fwd_s1 ? byp_s1 : ram_rdata;
	assign wr_data = {line[0], x_s1};
	assign new_col = {x_s1, line[0], line[1]};
	assign win[3]  = new_col;

	for (genvar i = 0; i < 3; i++) begin : g_cell
		bts_col_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(fire_s1),
			.col_in  (win[i+1]),
			.col     (win[i])
		);
	end

	// The window after this shift is win[1], win[2], new_col from west to east.
	assign ring = {win[1][0], win[1][1], win[1][2], win[2][2],
		new_col[2], new_col[1], new_col[0], win[2][0]};
	assign center  = win[2][1];
	assign removed = center && interior_s1 && bts_pkg::thin_remove(ring, pass_parity_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_s1) begin
			pixel_out_q   <= center && !removed;
			was_removed_q <= removed;
			frame_last_q  <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pixel_out_q;
	assign was_removed = was_removed_q;
	assign frame_last  = frame_last_q;

endmodule

[sv/bts_checker.sv]
module bts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_we,
	input logic [bts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input logic [bts_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              pixel_in,
	input logic                              is_pad,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              pixel_out,
	input logic                              was_removed,
	input logic                              frame_last
);

	// A waiting result word keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({pixel_out, was_removed, frame_last}))
		else $error("result word changed while stalled");

	// A deleted pixel always leaves as background.
	a_removed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_removed |-> !pixel_out)
		else $error("removed pixel left as foreground");

	// With the output register empty the window stage can always move.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

	// A fresh result rises only after an accepted word has passed the window stage and the output register.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a word two cycles earlier");

endmodule

bind binary_thinning_subpass bts_checker u_bts_checker (.*);
